>>> hw/rtl/qpv_pkg.sv
// Shared types, constants and sequencer states for the quadrature position and velocity unit.
package qpv_pkg;

  // Field widths.
  localparam int CNT_W = 16;
  localparam int ANG_W = 16;
  localparam int CFG_W = 16;
  localparam int IDX_W = 2;

  // Counts per revolution after reset and after an init command.
  localparam logic [CNT_W-1:0] DEFAULT_CPR = 16'd4096;

  // 256 steps per turn times one million microseconds per second.
  localparam logic [27:0] VEL_SCALE = 28'd256000000;

  // Shared divider: operand width and iteration counter width.
  localparam int DIV_W   = 48;
  localparam int DIV_IDX_W = 6;

  // Dividend widths, i.e. iteration counts, of the four divisions.
  localparam logic [DIV_IDX_W-1:0] DIV_BITS_CNT  = 6'd16;
  localparam logic [DIV_IDX_W-1:0] DIV_BITS_MECH = 6'd32;
  localparam logic [DIV_IDX_W-1:0] DIV_BITS_ELEC = 6'd40;
  localparam logic [DIV_IDX_W-1:0] DIV_BITS_VEL  = 6'd48;

  // Command codes; the unused code behaves as an update.
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_RESET  = 2'd1;
  localparam logic [1:0] CMD_INIT   = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_CPR    = 2'd0;
  localparam logic [IDX_W-1:0] REG_POLE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] counts_per_rev;
    logic [7:0]       pole_pair_cnt;
    logic [ANG_W-1:0] offset_angle;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [CNT_W-1:0] counter_value;
    logic [31:0]      now_us;
    logic             index_pin;
  } enc_t;

  typedef struct packed {
    logic [ANG_W-1:0]    mech_angle;
    logic [ANG_W-1:0]    elec_phase;
    logic signed [31:0]  velocity;
    logic [CNT_W-1:0]    last_counter;
    logic                direction;
    logic signed [31:0]  running_count;
    logic                index_latched;
  } est_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIV_W-1:0]     divisor;
    logic [DIV_IDX_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CURM,
    ST_CURM_WAIT,
    ST_MECH,
    ST_MECH_WAIT,
    ST_ELEC,
    ST_ELEC_WAIT,
    ST_DEN,
    ST_VEL,
    ST_VEL_WAIT,
    ST_FINISH
  } seq_state_t;

endpackage

>>> hw/rtl/qpv_if.sv
// Valid/ready channel interfaces for encoder samples and position estimates.
interface qpv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] counter_value;
  logic [31:0] now_us;
  logic        index_pin;

  modport source (output valid, cmd, counter_value, now_us, index_pin, input ready);
  modport sink (input valid, cmd, counter_value, now_us, index_pin, output ready);
endinterface

interface qpv_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        mech_angle;
  logic [15:0]        elec_phase;
  logic signed [31:0] velocity;
  logic [15:0]        last_counter;
  logic               direction;
  logic signed [31:0] running_count;
  logic               index_latched;

  modport source (output valid, mech_angle, elec_phase, velocity, last_counter, direction,
                  running_count, index_latched, input ready);
  modport sink (input valid, mech_angle, elec_phase, velocity, last_counter, direction,
                running_count, index_latched, output ready);
endinterface

>>> hw/rtl/quadrature_position_velocity_unit.sv
// Top level of the quadrature encoder position and velocity unit.
// Each encoder word carries a command, the sampled counter, a microsecond
// timestamp and the index pin level, and produces exactly one estimate word.
// A reset-count or init word goes straight to the finish state, which loads
// its estimate into the output register and returns the unit to idle.
// An update runs on one shared restoring divider (one quotient bit per
// cycle) and one shared multiplier under a sequencer: four divisions of 16,
// 32, 40 and 48 bits, the last skipped when no time has passed since the
// last word, lead to the finish state that loads the output register.
// The unit takes no new word while one is in flight; a finished estimate
// waits in the output register, and a new word may be accepted meanwhile.
// A second finished estimate holds the sequencer, and with it the input,
// until the output register is emptied.
// Configuration writes are meant for idle periods; a write of zero to the
// counts per revolution or the pole pair count is ignored, and init
// restores counts_per_rev.
module quadrature_position_velocity_unit import qpv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  qpv_in_if.sink           enc,
  qpv_out_if.source        est
);

  cfg_t cfg;
  enc_t item;
  est_t res;
  est_t est_q;
  logic out_valid;
  logic res_ready;
  logic go;
  logic idle;
  logic done;
  logic cpr_reload;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counts_per_rev <= DEFAULT_CPR;
      cfg.pole_pair_cnt  <= 8'd1;
      cfg.offset_angle   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CPR: begin
          if (cfg_data != '0) cfg.counts_per_rev <= cfg_data;
        end
        REG_POLE: begin
          if (cfg_data[7:0] != 8'd0) cfg.pole_pair_cnt <= cfg_data[7:0];
        end
        REG_OFFSET: cfg.offset_angle <= cfg_data;
        default: ;
      endcase
    end else if (cpr_reload) begin
      cfg.counts_per_rev <= DEFAULT_CPR;
    end
  end

  // Input word handoff to the sequencer.
  assign enc.ready          = idle;
  assign go                 = enc.valid && idle;
  assign item.cmd           = enc.cmd;
  assign item.counter_value = enc.counter_value;
  assign item.now_us        = enc.now_us;
  assign item.index_pin     = enc.index_pin;

  qpv_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .go         (go),
    .item       (item),
    .res_ready  (res_ready),
    .idle       (idle),
    .done       (done),
    .cpr_reload (cpr_reload),
    .res        (res)
  );

  // Output register: refills in the same cycle the held word is taken.
  assign res_ready = !out_valid || est.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && res_ready) begin
      out_valid <= 1'b1;
    end else if (est.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_ready) begin
      est_q <= res;
    end
  end

  assign est.valid         = out_valid;
  assign est.mech_angle    = est_q.mech_angle;
  assign est.elec_phase    = est_q.elec_phase;
  assign est.velocity      = est_q.velocity;
  assign est.last_counter  = est_q.last_counter;
  assign est.direction     = est_q.direction;
  assign est.running_count = est_q.running_count;
  assign est.index_latched = est_q.index_latched;

endmodule

>>> hw/rtl/qpv_div.sv
// Shared restoring divider that retires one quotient bit per cycle.
module qpv_div import qpv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_IDX_W-1:0] idx;
  logic [DIV_W-1:0]     dvd;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quot;

  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;
  logic           ge;

  // Bring down the next dividend bit and try one subtraction.
  always_comb begin
    shifted = {rem, dvd[idx]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  // Control: busy while bits remain, done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && idx == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      dvs  <= req.divisor;
      rem  <= '0;
      quot <= '0;
      idx  <= req.nbits - 1'b1;
    end else if (busy) begin
      rem  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quot <= {quot[DIV_W-2:0], ge};
      idx  <= idx - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

>>> hw/rtl/qpv_mul.sv
// Shared 32 by 32 multiplier with a registered product that holds until the next enable.
module qpv_mul import qpv_pkg::*; (
  input  logic        clk,
  input  mul_req_t    req,
  output logic [63:0] prod
);

  // Product register loads only when a step asks for a multiply.
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= {32'b0, req.a} * {32'b0, req.b};
    end
  end

endmodule

>>> hw/rtl/qpv_core.sv
// Sequencer and datapath that run one encoder word through the shared multiplier and divider.
module qpv_core import qpv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic go,
  input  enc_t item,
  input  logic res_ready,
  output logic idle,
  output logic done,
  output logic cpr_reload,
  output est_t res
);

  seq_state_t state;
  seq_state_t state_next;

  // Architectural state.
  logic [CNT_W-1:0] prev_count;
  logic [31:0]      prev_time;
  logic [31:0]      acc;
  logic             prev_idx;
  logic             flag;
  logic             last_dir;

  // Captured word and intermediate results.
  logic [1:0]        cmd_q;
  logic [CNT_W-1:0]  cur_q;
  logic [31:0]       now_q;
  logic              pin_q;
  logic signed [17:0] delta;
  logic [16:0]       mag;
  logic [31:0]       elapsed;
  logic [CNT_W-1:0]  oc;
  logic [CNT_W-1:0]  mpos;
  logic [ANG_W-1:0]  mech;
  logic [ANG_W-1:0]  elec;
  logic [44:0]       num;
  logic [31:0]       vel;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  mul_req_t    mul_req;
  logic [63:0] prod;

  logic commit;

  qpv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  qpv_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // Count change wrapped once toward plus or minus half a revolution.
  logic signed [17:0] d0;
  logic signed [17:0] half;
  logic signed [17:0] cpr_s;
  logic signed [17:0] dw;
  logic signed [17:0] dw_neg;

  always_comb begin
    d0     = $signed({2'b00, cur_q}) - $signed({2'b00, prev_count});
    half   = $signed({3'b000, cfg.counts_per_rev[CNT_W-1:1]});
    cpr_s  = $signed({2'b00, cfg.counts_per_rev});
    if (d0 > half) begin
      dw = d0 - cpr_s;
    end else if (d0 < -half) begin
      dw = d0 + cpr_s;
    end else begin
      dw = d0;
    end
    dw_neg = -dw;
  end

  // Offset in counts, rounded, then reduced by one revolution if needed.
  logic [32:0] oc_sum;
  logic [16:0] oc_raw;
  logic [16:0] oc_sub;

  always_comb begin
    oc_sum = {1'b0, prod[31:0]} + 33'd32768;
    oc_raw = oc_sum[32:16];
    oc_sub = oc_raw - {1'b0, cfg.counts_per_rev};
  end

  // Offset-corrected position within one revolution.
  logic [16:0] m_sum;
  logic [16:0] m_sub;

  always_comb begin
    m_sum = {1'b0, div_rsp.rem[CNT_W-1:0]} + {1'b0, cfg.counts_per_rev} - {1'b0, oc};
    m_sub = m_sum - {1'b0, cfg.counts_per_rev};
  end

  // Velocity: saturate the magnitude quotient, then apply the sign.
  logic [31:0] vel_sat;

  always_comb begin
    if (delta[17]) begin
      if (div_rsp.quot > 48'h0000_8000_0000) begin
        vel_sat = 32'h8000_0000;
      end else begin
        vel_sat = div_rsp.quot[31:0];
      end
    end else begin
      if (div_rsp.quot > 48'h0000_7FFF_FFFF) begin
        vel_sat = 32'h7FFF_FFFF;
      end else begin
        vel_sat = div_rsp.quot[31:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (go) begin
          if (item.cmd == CMD_RESET || item.cmd == CMD_INIT) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP:      state_next = ST_CURM;
      ST_CURM:      state_next = ST_CURM_WAIT;
      ST_CURM_WAIT: if (div_rsp.done) state_next = ST_MECH;
      ST_MECH:      state_next = ST_MECH_WAIT;
      ST_MECH_WAIT: if (div_rsp.done) state_next = ST_ELEC;
      ST_ELEC:      state_next = ST_ELEC_WAIT;
      ST_ELEC_WAIT: if (div_rsp.done) state_next = ST_DEN;
      ST_DEN:       state_next = ST_VEL;
      ST_VEL: begin
        if (elapsed == 32'd0) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_VEL_WAIT;
        end
      end
      ST_VEL_WAIT:  if (div_rsp.done) state_next = ST_FINISH;
      ST_FINISH:    if (res_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs: requests to the shared units and the handshake strobes.
  always_comb begin
    div_req = '0;
    mul_req = '0;
    idle    = 1'b0;
    done    = 1'b0;
    unique case (state)
      ST_IDLE: idle = 1'b1;
      ST_PREP: begin
        mul_req.en = 1'b1;
        mul_req.a  = {16'b0, cfg.offset_angle};
        mul_req.b  = {16'b0, cfg.counts_per_rev};
      end
      ST_CURM: begin
        div_req.start    = 1'b1;
        div_req.dividend = {32'b0, cur_q};
        div_req.divisor  = {32'b0, cfg.counts_per_rev};
        div_req.nbits    = DIV_BITS_CNT;
      end
      ST_MECH: begin
        div_req.start    = 1'b1;
        div_req.dividend = {16'b0, mpos, 16'b0};
        div_req.divisor  = {32'b0, cfg.counts_per_rev};
        div_req.nbits    = DIV_BITS_MECH;
        mul_req.en       = 1'b1;
        mul_req.a        = {16'b0, mpos};
        mul_req.b        = {24'b0, cfg.pole_pair_cnt};
      end
      ST_ELEC: begin
        div_req.start    = 1'b1;
        div_req.dividend = {8'b0, prod[23:0], 16'b0};
        div_req.divisor  = {32'b0, cfg.counts_per_rev};
        div_req.nbits    = DIV_BITS_ELEC;
        mul_req.en       = 1'b1;
        mul_req.a        = {15'b0, mag};
        mul_req.b        = {4'b0, VEL_SCALE};
      end
      ST_DEN: begin
        mul_req.en = 1'b1;
        mul_req.a  = {16'b0, cfg.counts_per_rev};
        mul_req.b  = elapsed;
      end
      ST_VEL: begin
        if (elapsed != 32'd0) begin
          div_req.start    = 1'b1;
          div_req.dividend = {3'b0, num};
          div_req.divisor  = prod[DIV_W-1:0];
          div_req.nbits    = DIV_BITS_VEL;
        end
      end
      ST_FINISH: done = 1'b1;
      default: ;
    endcase
  end

  assign commit     = (state == ST_FINISH) && res_ready;
  assign cpr_reload = commit && (cmd_q == CMD_INIT);

  // Values an update leaves behind.
  logic [31:0] acc_new;
  logic        flag_new;

  always_comb begin
    acc_new  = acc + {{14{delta[17]}}, delta};
    flag_new = flag | (pin_q & ~prev_idx);
  end

  // Result word for the command in flight.
  always_comb begin
    unique case (cmd_q)
      CMD_RESET: begin
        res.mech_angle    = '0;
        res.elec_phase    = cfg.offset_angle;
        res.velocity      = '0;
        res.last_counter  = '0;
        res.direction     = last_dir;
        res.running_count = '0;
        res.index_latched = flag;
      end
      CMD_INIT: begin
        res.mech_angle    = '0;
        res.elec_phase    = '0;
        res.velocity      = '0;
        res.last_counter  = cur_q;
        res.direction     = 1'b1;
        res.running_count = '0;
        res.index_latched = 1'b0;
      end
      default: begin
        res.mech_angle    = mech;
        res.elec_phase    = elec;
        res.velocity      = $signed(vel);
        res.last_counter  = cur_q;
        res.direction     = ~delta[17];
        res.running_count = $signed(acc_new);
        res.index_latched = flag_new;
      end
    endcase
  end

  // Sequencer state and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev_count <= '0;
      prev_time  <= '0;
      acc        <= '0;
      prev_idx   <= 1'b0;
      flag       <= 1'b0;
      last_dir   <= 1'b1;
    end else begin
      state <= state_next;
      if (commit) begin
        prev_time <= now_q;
        unique case (cmd_q)
          CMD_RESET: begin
            prev_count <= '0;
            acc        <= '0;
          end
          CMD_INIT: begin
            prev_count <= cur_q;
            prev_idx   <= pin_q;
            acc        <= '0;
            flag       <= 1'b0;
            last_dir   <= 1'b1;
          end
          default: begin
            prev_count <= cur_q;
            acc        <= acc_new;
            last_dir   <= ~delta[17];
            prev_idx   <= pin_q;
            flag       <= flag_new;
          end
        endcase
      end
    end
  end

  // Intermediate results, each loaded by the step that produces it.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && go) begin
      cmd_q <= item.cmd;
      cur_q <= item.counter_value;
      now_q <= item.now_us;
      pin_q <= item.index_pin;
    end
    if (state == ST_PREP) begin
      delta   <= dw;
      mag     <= dw[17] ? dw_neg[16:0] : dw[16:0];
      elapsed <= now_q - prev_time;
    end
    if (state == ST_CURM) begin
      oc <= (oc_raw >= {1'b0, cfg.counts_per_rev}) ? oc_sub[CNT_W-1:0] : oc_raw[CNT_W-1:0];
    end
    if (state == ST_CURM_WAIT && div_rsp.done) begin
      mpos <= (m_sum >= {1'b0, cfg.counts_per_rev}) ? m_sub[CNT_W-1:0] : m_sum[CNT_W-1:0];
    end
    if (state == ST_MECH_WAIT && div_rsp.done) begin
      mech <= div_rsp.quot[ANG_W-1:0];
    end
    if (state == ST_ELEC_WAIT && div_rsp.done) begin
      elec <= div_rsp.quot[ANG_W-1:0];
    end
    if (state == ST_DEN) begin
      num <= prod[44:0];
    end
    if (state == ST_VEL && elapsed == 32'd0) begin
      vel <= '0;
    end
    if (state == ST_VEL_WAIT && div_rsp.done) begin
      vel <= delta[17] ? (32'd0 - vel_sat) : vel_sat;
    end
  end

endmodule
